// ----- src/jrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the Jacobi relaxation sweep.
package jrs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_SLOTS   = 3 * MAX_WIDTH;
    localparam int EL_W        = $clog2(ROW_SLOTS);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int VAL_W       = 32;
    localparam int ERR_W       = 64;
    localparam int GW_W        = 9;
    localparam int GH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int SUM_W       = VAL_W + 3;
    localparam int OUT_FIELD_W = ROW_W + EL_W + VAL_W + ERR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // floor(x / 3) for a 34-bit x: x = hi * 2^17 + lo, 2^17 = 3 * 43690 + 2
    localparam int DIV3_SPLIT = 17;
    localparam int DIV3_HI_W  = 17;
    localparam int DIV3_T_W   = 19;
    localparam logic [15:0] DIV3_HI_MUL = 16'd43690;
    localparam logic [18:0] DIV3_K      = 19'd349526;
    localparam int DIV3_SHIFT = 20;

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic            en;
        logic            bank;
        logic [EL_W-1:0] el;
        logic [EL_W-1:0] right_el;
    } t_buf_req;

endpackage

// ----- src/jrs_line_buf.sv -----
`timescale 1ns / 1ps
// Two-row line buffer: one bank written per row, neighbors read from both banks.
module jrs_line_buf (
    input  logic                      i_clk,
    input  jrs_pkg::t_buf_req         i_req,
    input  logic [jrs_pkg::VAL_W-1:0] i_wdata,
    output logic [jrs_pkg::VAL_W-1:0] o_centre,
    output logic [jrs_pkg::VAL_W-1:0] o_right,
    output logic [jrs_pkg::VAL_W-1:0] o_up
);

    logic [jrs_pkg::VAL_W-1:0] r_mem0 [jrs_pkg::ROW_SLOTS];
    logic [jrs_pkg::VAL_W-1:0] r_mem1 [jrs_pkg::ROW_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.bank) begin
            r_mem0[i_req.el] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.bank) begin
            r_mem1[i_req.el] <= i_wdata;
        end
    end

    // up comes from the bank being overwritten (old data), centre/right from the other
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.bank) begin
                o_up     <= r_mem1[i_req.el];
                o_centre <= r_mem0[i_req.el];
                o_right  <= r_mem0[i_req.right_el];
            end else begin
                o_up     <= r_mem0[i_req.el];
                o_centre <= r_mem1[i_req.el];
                o_right  <= r_mem1[i_req.right_el];
            end
        end
    end

endmodule

// ----- src/jacobi_relaxation_sweep.sv -----
`timescale 1ns / 1ps
// Jacobi five-point relaxation sweep over a three-channel raster grid, one element per item.
// Throughput: one item per cycle while the output accepts results; in the last grid row each
// item yields two results, and the single output port holds off new items until both are taken.
// Reset: counters, pipeline, error sum cleared, geometry 256 x 256; line buffer not cleared.
module jacobi_relaxation_sweep (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [jrs_pkg::VAL_W-1:0]          s_axis_tdata,  // value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [jrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // row_index, element_index,
                                                              // smoothed, error_sum, zero pad
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [0:0]                         i_cfg_index,
    input  logic [jrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NST = 6;

    typedef struct packed {
        logic [jrs_pkg::ROW_W-1:0] row;
        logic [jrs_pkg::EL_W-1:0]  el;
        logic [jrs_pkg::VAL_W-1:0] v;
        logic                      has_a;
        logic                      has_b;
        logic                      interior;
        logic                      fin;
    } t_tag;

    // geometry
    logic [jrs_pkg::EL_W-1:0]  r_nlast, n_nlast;
    logic [jrs_pkg::ROW_W-1:0] r_hlast, n_hlast;
    logic [jrs_pkg::GW_W-1:0]  w_cl;
    logic [jrs_pkg::GH_W-1:0]  h_cl;
    logic [jrs_pkg::GH_W-1:0]  h_m1;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cl = i_cfg_data[jrs_pkg::GW_W-1:0];
        if (w_cl < jrs_pkg::GW_W'(3)) begin
            w_cl = jrs_pkg::GW_W'(3);
        end else if (w_cl > jrs_pkg::GW_W'(jrs_pkg::MAX_WIDTH)) begin
            w_cl = jrs_pkg::GW_W'(jrs_pkg::MAX_WIDTH);
        end
        h_cl = i_cfg_data[jrs_pkg::GH_W-1:0];
        if (h_cl < jrs_pkg::GH_W'(3)) begin
            h_cl = jrs_pkg::GH_W'(3);
        end else if (h_cl > jrs_pkg::GH_W'(jrs_pkg::MAX_HEIGHT)) begin
            h_cl = jrs_pkg::GH_W'(jrs_pkg::MAX_HEIGHT);
        end
        h_m1 = h_cl - jrs_pkg::GH_W'(1);
        n_nlast = r_nlast;
        n_hlast = r_hlast;
        if (i_cfg_valid) begin
            case (jrs_pkg::t_cfg_idx'(i_cfg_index))
                jrs_pkg::CFG_GRID_WIDTH: begin
                    n_nlast = jrs_pkg::EL_W'({1'b0, w_cl}) + jrs_pkg::EL_W'({w_cl, 1'b0})
                              - jrs_pkg::EL_W'(1);
                end
                jrs_pkg::CFG_GRID_HEIGHT: begin
                    n_hlast = h_m1[jrs_pkg::ROW_W-1:0];
                end
                default: begin
                    n_nlast = r_nlast;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlast <= jrs_pkg::EL_W'(3 * jrs_pkg::MAX_WIDTH - 1);
            r_hlast <= jrs_pkg::ROW_W'(255);
        end else begin
            r_nlast <= n_nlast;
            r_hlast <= n_hlast;
        end
    end

    // pipeline control
    logic [NST-1:0] r_vld;
    logic [NST:0]   rdy;
    logic [NST-1:0] go;
    logic           accept;
    logic           slot_rdy;
    logic           out_hs;
    logic           r_has_a, n_has_a;
    logic           r_has_b, n_has_b;

    assign out_hs   = m_axis_tvalid && m_axis_tready;
    assign slot_rdy = (!r_has_a && !r_has_b) || ((r_has_a ^ r_has_b) && out_hs);

    always_comb begin
        rdy[NST] = slot_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        for (int k = 0; k < NST; k++) begin
            go[k] = r_vld[k] && rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign accept        = s_axis_tvalid && rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= accept;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= go[k-1];
                end
            end
        end
    end

    // raster position
    logic [jrs_pkg::ROW_W-1:0] r_row, n_row;
    logic [jrs_pkg::EL_W-1:0]  r_el, n_el;
    logic                      last_col;
    logic                      last_row;
    logic                      interior;
    t_tag                      tag_in;
    jrs_pkg::t_buf_req         buf_req;

    always_comb begin
        last_col = r_el >= r_nlast;
        last_row = r_row >= r_hlast;
        interior = (r_row >= jrs_pkg::ROW_W'(2)) && (r_row <= r_hlast)
                   && (r_el >= jrs_pkg::EL_W'(3))
                   && (({1'b0, r_el} + (jrs_pkg::EL_W+1)'(3)) <= {1'b0, r_nlast});
        tag_in.row      = r_row;
        tag_in.el       = r_el;
        tag_in.v        = s_axis_tdata;
        tag_in.has_a    = r_row != '0;
        tag_in.has_b    = last_row;
        tag_in.interior = interior;
        tag_in.fin      = last_row && last_col;
        buf_req.en       = accept;
        buf_req.bank     = r_row[0];
        buf_req.el       = r_el;
        buf_req.right_el = interior ? r_el + jrs_pkg::EL_W'(3) : r_el;
        n_row = r_row;
        n_el  = r_el;
        if (accept) begin
            if (last_col) begin
                n_el  = '0;
                n_row = last_row ? '0 : r_row + jrs_pkg::ROW_W'(1);
            end else begin
                n_el = r_el + jrs_pkg::EL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_el  <= '0;
        end else begin
            r_row <= n_row;
            r_el  <= n_el;
        end
    end

    logic [jrs_pkg::VAL_W-1:0] centre;
    logic [jrs_pkg::VAL_W-1:0] right_v;
    logic [jrs_pkg::VAL_W-1:0] up_v;

    jrs_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_req    (buf_req),
        .i_wdata  (s_axis_tdata),
        .o_centre (centre),
        .o_right  (right_v),
        .o_up     (up_v)
    );

    // datapath stages
    t_tag                            r_tag [NST];
    logic [jrs_pkg::VAL_W-1:0]       r_hist [3];
    logic [jrs_pkg::SUM_W-1:0]       r_sum2;
    logic [jrs_pkg::VAL_W-1:0]       r_cen2, r_cen3, r_cen4;
    logic [jrs_pkg::VAL_W:0]         r_q1_3;
    logic [jrs_pkg::DIV3_T_W-1:0]    r_t3;
    logic [jrs_pkg::VAL_W-1:0]       r_res4, r_res5, r_res6;
    logic [jrs_pkg::VAL_W-1:0]       r_dif5;
    logic [2*jrs_pkg::VAL_W-1:0]     r_sq6;
    logic [jrs_pkg::SUM_W-1:0]       sum;
    logic [jrs_pkg::SUM_W-2:0]       half;
    logic [jrs_pkg::DIV3_HI_W-1:0]   xh;
    logic [jrs_pkg::DIV3_SPLIT-1:0]  xl;
    logic [2*jrs_pkg::DIV3_T_W-1:0]  tk;
    logic [jrs_pkg::VAL_W:0]         quot;

    always_comb begin
        sum  = jrs_pkg::SUM_W'(r_hist[2]) + jrs_pkg::SUM_W'(right_v)
               + jrs_pkg::SUM_W'(up_v) + jrs_pkg::SUM_W'(r_tag[0].v)
               + jrs_pkg::SUM_W'({centre, 1'b0});
        half = r_sum2[jrs_pkg::SUM_W-1:1];
        xh   = half[jrs_pkg::SUM_W-2:jrs_pkg::DIV3_SPLIT];
        xl   = half[jrs_pkg::DIV3_SPLIT-1:0];
        tk   = r_t3 * jrs_pkg::DIV3_K;
        quot = r_q1_3 + (jrs_pkg::VAL_W+1)'(tk[2*jrs_pkg::DIV3_T_W-1:jrs_pkg::DIV3_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && accept) begin
            r_tag[0] <= tag_in;
        end
        if (go[0]) begin
            r_hist[0] <= centre;
            r_hist[1] <= r_hist[0];
            r_hist[2] <= r_hist[1];
        end
        if (rdy[1] && go[0]) begin
            r_tag[1] <= r_tag[0];
            r_sum2   <= sum;
            r_cen2   <= centre;
        end
        if (rdy[2] && go[1]) begin
            r_tag[2] <= r_tag[1];
            r_q1_3   <= xh * jrs_pkg::DIV3_HI_MUL;
            r_t3     <= jrs_pkg::DIV3_T_W'({xh, 1'b0}) + jrs_pkg::DIV3_T_W'(xl);
            r_cen3   <= r_cen2;
        end
        if (rdy[3] && go[2]) begin
            r_tag[3] <= r_tag[2];
            r_res4   <= r_tag[2].interior ? quot[jrs_pkg::VAL_W-1:0] : r_cen3;
            r_cen4   <= r_cen3;
        end
        if (rdy[4] && go[3]) begin
            r_tag[4] <= r_tag[3];
            r_res5   <= r_res4;
            r_dif5   <= (r_res4 >= r_cen4) ? r_res4 - r_cen4 : r_cen4 - r_res4;
        end
        if (rdy[5] && go[4]) begin
            r_tag[5] <= r_tag[4];
            r_res6   <= r_res5;
            r_sq6    <= r_dif5 * r_dif5;
        end
    end

    // output slot: relaxed result of the previous row first, then last-row pass-through
    logic                      slot_load;
    logic [jrs_pkg::ERR_W-1:0] r_acc, n_acc;
    logic [jrs_pkg::ERR_W:0]   acc_sum;
    logic [jrs_pkg::ERR_W-1:0] acc_new;
    logic [jrs_pkg::ROW_W-1:0] r_a_row, r_b_row;
    logic [jrs_pkg::EL_W-1:0]  r_a_el, r_b_el;
    logic [jrs_pkg::VAL_W-1:0] r_a_val, r_b_val;
    logic [jrs_pkg::ERR_W-1:0] r_b_err;
    logic                      r_b_fin;

    assign slot_load = rdy[NST] && go[NST-1];

    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_sq6};
        acc_new = r_acc;
        if (r_tag[NST-1].interior) begin
            acc_new = acc_sum[jrs_pkg::ERR_W] ? '1 : acc_sum[jrs_pkg::ERR_W-1:0];
        end
        n_acc   = r_acc;
        n_has_a = r_has_a;
        n_has_b = r_has_b;
        if (out_hs) begin
            if (r_has_a) begin
                n_has_a = 1'b0;
            end else begin
                n_has_b = 1'b0;
            end
        end
        if (slot_load) begin
            n_has_a = r_tag[NST-1].has_a;
            n_has_b = r_tag[NST-1].has_b;
            n_acc   = r_tag[NST-1].fin ? '0 : acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_has_a <= 1'b0;
            r_has_b <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_has_a <= n_has_a;
            r_has_b <= n_has_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_load) begin
            r_a_row <= r_tag[NST-1].row - jrs_pkg::ROW_W'(1);
            r_a_el  <= r_tag[NST-1].el;
            r_a_val <= r_res6;
            r_b_row <= r_tag[NST-1].row;
            r_b_el  <= r_tag[NST-1].el;
            r_b_val <= r_tag[NST-1].v;
            r_b_err <= r_tag[NST-1].fin ? acc_new : '0;
            r_b_fin <= r_tag[NST-1].fin;
        end
    end

    always_comb begin
        m_axis_tvalid = r_has_a || r_has_b;
        if (r_has_a) begin
            m_axis_tdata = jrs_pkg::OUT_TDATA_W'({jrs_pkg::ERR_W'(0), r_a_val, r_a_el, r_a_row});
            m_axis_tlast = 1'b0;
        end else begin
            m_axis_tdata = jrs_pkg::OUT_TDATA_W'({r_b_err, r_b_val, r_b_el, r_b_row});
            m_axis_tlast = r_b_fin;
        end
    end

    // checks
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_err_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[117:54] == '0)
        else $error("error sum nonzero on a result that is not last");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hs && r_has_a && r_has_b |=> m_axis_tvalid && !r_has_a)
        else $error("pass-through result lost after relaxed result");

endmodule

// ----- tb/sv/tb_jacobi_relaxation_sweep.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Jacobi relaxation sweep against a line-buffer predictor.
module tb_jacobi_relaxation_sweep;

    localparam int ROW_W       = jrs_pkg::ROW_W;
    localparam int EL_W        = jrs_pkg::EL_W;
    localparam int VAL_W       = jrs_pkg::VAL_W;
    localparam int ERR_W       = jrs_pkg::ERR_W;
    localparam int GW_W        = jrs_pkg::GW_W;
    localparam int GH_W        = jrs_pkg::GH_W;
    localparam int CFG_DATA_W  = jrs_pkg::CFG_DATA_W;
    localparam int OUT_TDATA_W = jrs_pkg::OUT_TDATA_W;
    localparam int ROW_SLOTS   = jrs_pkg::ROW_SLOTS;
    localparam int MAX_WIDTH   = jrs_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = jrs_pkg::MAX_HEIGHT;

    localparam int EL_LSB  = ROW_W;
    localparam int VAL_LSB = ROW_W + EL_W;
    localparam int ERR_LSB = ROW_W + EL_W + VAL_W;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             hold_until_drained;
    } t_grid_item;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [EL_W-1:0]  element_index;
        logic [VAL_W-1:0] smoothed;
        logic [ERR_W-1:0] error_sum;
        logic             last;
    } t_relaxed_elem;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [VAL_W-1:0]       s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [0:0]             i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    jacobi_relaxation_sweep u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_grid_item    grid_feed_q[$];
    t_relaxed_elem relaxed_q[$];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            items_sent = 0;

    // predictor state
    logic [GW_W-1:0]  cfg_width = 9'd256;
    logic [GH_W-1:0]  cfg_height = 13'd256;
    logic [VAL_W-1:0] line_buf [2][ROW_SLOTS];
    logic [ROW_W-1:0] row_ptr = '0;
    logic [EL_W-1:0]  col_ptr = '0;
    logic [ERR_W-1:0] err_acc = '0;

    function automatic int eff_width(input logic [GW_W-1:0] d);
        return (d < 3) ? 3 : ((d > MAX_WIDTH) ? MAX_WIDTH : int'(d));
    endfunction

    function automatic int eff_height(input logic [GH_W-1:0] d);
        return (d < 3) ? 3 : ((d > MAX_HEIGHT) ? MAX_HEIGHT : int'(d));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic relax_element(input logic [VAL_W-1:0] v);
        int               n, h, r, e, pb;
        bit               last_col, last_row;
        logic [VAL_W-1:0] centre, newval;
        logic [ERR_W-1:0] total, diff, sq;
        n = 3 * eff_width(cfg_width);
        h = eff_height(cfg_height);
        r = int'(row_ptr);
        e = int'(col_ptr);
        last_col = (e >= n - 1);
        last_row = (r >= h - 1);
        if (r >= 1) begin
            pb = (r - 1) & 1;
            centre = line_buf[pb][e];
            newval = centre;
            if (r >= 2 && r <= h - 1 && e >= 3 && e + 4 <= n) begin
                total = ERR_W'(line_buf[pb][e-3]) + ERR_W'(line_buf[pb][e+3])
                      + ERR_W'(line_buf[r & 1][e]) + ERR_W'(v) + (ERR_W'(centre) << 1);
                newval = VAL_W'(total / 6);
                diff = (newval >= centre) ? ERR_W'(newval - centre) : ERR_W'(centre - newval);
                sq = diff * diff;
                err_acc = (err_acc > ~sq) ? '1 : err_acc + sq;
            end
            relaxed_q.push_back(t_relaxed_elem'{ROW_W'(r - 1), EL_W'(e), newval, '0, 1'b0});
        end
        line_buf[r & 1][e] = v;
        if (last_row)
            relaxed_q.push_back(t_relaxed_elem'{ROW_W'(r), EL_W'(e), v,
                                  last_col ? err_acc : '0, last_col});
        if (last_col) begin
            col_ptr = '0;
            if (last_row) begin
                row_ptr = '0;
                err_acc = '0;
            end else begin
                row_ptr = ROW_W'(r + 1);
            end
        end else begin
            col_ptr = EL_W'(e + 1);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                relax_element(s_axis_tdata);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (grid_feed_q.size() != 0
                    && !(grid_feed_q[0].hold_until_drained && relaxed_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= grid_feed_q[0].value;
                    grid_feed_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_relaxed_elem want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (relaxed_q.size() == 0) begin
                    report_mismatch("result with no expectation waiting");
                end else begin
                    want = relaxed_q.pop_front();
                    if (m_axis_tdata[EL_LSB-1:0] !== want.row_index)
                        report_mismatch($sformatf("row_index %0d, expected %0d",
                            m_axis_tdata[EL_LSB-1:0], want.row_index));
                    if (m_axis_tdata[VAL_LSB-1:EL_LSB] !== want.element_index)
                        report_mismatch($sformatf("element_index %0d, expected %0d",
                            m_axis_tdata[VAL_LSB-1:EL_LSB], want.element_index));
                    if (m_axis_tdata[ERR_LSB-1:VAL_LSB] !== want.smoothed)
                        report_mismatch($sformatf("smoothed %h, expected %h at row %0d el %0d",
                            m_axis_tdata[ERR_LSB-1:VAL_LSB], want.smoothed,
                            want.row_index, want.element_index));
                    if (m_axis_tdata[ERR_LSB+ERR_W-1:ERR_LSB] !== want.error_sum)
                        report_mismatch($sformatf("error_sum %h, expected %h",
                            m_axis_tdata[ERR_LSB+ERR_W-1:ERR_LSB], want.error_sum));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b at row %0d el %0d",
                            m_axis_tlast, want.last, want.row_index, want.element_index));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input jrs_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == jrs_pkg::CFG_GRID_WIDTH)
            cfg_width = data[GW_W-1:0];
        else
            cfg_height = data[GH_W-1:0];
    endtask

    task automatic run_sweep(input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data,
                             input bit directed, input int send_pct, input int recv_pct);
        int         w, h;
        t_grid_item it;
        write_reg(jrs_pkg::CFG_GRID_WIDTH, width_data);
        write_reg(jrs_pkg::CFG_GRID_HEIGHT, height_data);
        w = eff_width(width_data[GW_W-1:0]);
        h = eff_height(height_data[GH_W-1:0]);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int r = 0; r < h; r++) begin
            for (int e = 0; e < 3 * w; e++) begin
                if (directed) begin
                    // max center pixel in the middle row, max corners elsewhere
                    it.value = ((r == 1) == (e / 3 == 1)) ? '1 : '0;
                    it.hold_until_drained = (r == 1 && e == 4);
                end else begin
                    case ($urandom_range(9))
                        0:       it.value = '0;
                        1:       it.value = '1;
                        2:       it.value = {16'($urandom_range(0, 15)), 16'($urandom)};
                        3:       it.value = {16'($urandom_range(16'hFFF0, 16'hFFFF)),
                                             16'($urandom)};
                        default: it.value = $urandom;
                    endcase
                    it.hold_until_drained = ($urandom_range(199) == 0);
                end
                grid_feed_q.push_back(it);
            end
        end
        items_sent += 3 * w * h;
        do @(posedge i_clk);
        while (grid_feed_q.size() != 0 || s_axis_tvalid || relaxed_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int                    sweep_no;
        logic [CFG_DATA_W-1:0] wd, hd;
        sweep_no = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest grid through clamped zeros, error sum saturates
        run_sweep('0, '0, 1'b1, 0, 0);
        run_sweep(13'd3, 13'd3, 1'b0, 69, 0);
        // upper width bits ignored
        run_sweep(13'h1E18, 13'd4, 1'b0, 0, 69);
        run_sweep(13'd3, 13'd9, 1'b0, 21, 21);

        while (items_sent < 1250) begin
            wd = {4'($urandom), 9'($urandom_range(3, 8))};
            if ($urandom_range(7) == 0)
                wd[GW_W-1:0] = 9'($urandom_range(0, 2));
            hd = ($urandom_range(7) == 0) ? 13'($urandom_range(0, 2))
                                          : 13'($urandom_range(3, 6));
            case (sweep_no % 4)
                0: run_sweep(wd, hd, 1'b0, 0, 0);
                1: run_sweep(wd, hd, 1'b0, 69, 0);
                2: run_sweep(wd, hd, 1'b0, 0, 69);
                default: run_sweep(wd, hd, 1'b0, 21, 21);
            endcase
            sweep_no++;
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** jacobi_relaxation_sweep: PASSED **");
        else
            $display("** jacobi_relaxation_sweep: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** jacobi_relaxation_sweep: FAILED **");
        $finish;
    end

endmodule
